[rtl/mmts_pkg.sv]
// Shared types and constants for the min/max tracking stack.
// No dependencies; used by mmts_cell, the top level and the bench.
package mmts_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IDX_W = 8;
  localparam int FUNC_W = 2;

  // Operation codes on the func field; the fourth code is ignored.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  // Broadcast control for the row of stack cells.
  typedef struct packed {
    logic push;   // every cell takes its upper neighbor
    logic pop;    // every cell takes its lower neighbor
    logic load;   // read carry loads the lower neighbor's element
    logic shift;  // read carry moves one cell toward the top
  } cell_ctrl_t;

endpackage

[rtl/mmts_cell.sv]
// One stack position: element, prefix min/max and a read carry register.
// Depends on mmts_pkg (cell_ctrl_t).
module mmts_cell #(
  parameter int DATA_WIDTH = mmts_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  mmts_pkg::cell_ctrl_t          ctrl,
  input  logic signed [DATA_WIDTH-1:0]  up_elem,
  input  logic signed [DATA_WIDTH-1:0]  up_min,
  input  logic signed [DATA_WIDTH-1:0]  up_max,
  input  logic signed [DATA_WIDTH-1:0]  dn_elem,
  input  logic signed [DATA_WIDTH-1:0]  dn_min,
  input  logic signed [DATA_WIDTH-1:0]  dn_max,
  input  logic signed [DATA_WIDTH-1:0]  dn_carry,
  output logic signed [DATA_WIDTH-1:0]  elem,
  output logic signed [DATA_WIDTH-1:0]  pmin,
  output logic signed [DATA_WIDTH-1:0]  pmax,
  output logic signed [DATA_WIDTH-1:0]  carry
);

  always_ff @(posedge clk) begin
    priority if (ctrl.push) begin
      elem <= up_elem;
      pmin <= up_min;
      pmax <= up_max;
    end else if (ctrl.pop) begin
      elem <= dn_elem;
      pmin <= dn_min;
      pmax <= dn_max;
    end else begin
      elem <= elem;
      pmin <= pmin;
      pmax <= pmax;
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      carry <= dn_elem;
    end else if (ctrl.shift) begin
      carry <= dn_carry;
    end else begin
      carry <= carry;
    end
  end

endmodule

[rtl/mmts_out_buf.sv]
// Two-word result buffer between the stack core and the output channel.
// Depends on nothing but its WIDTH parameter.
module mmts_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] slot0;
  logic [WIDTH-1:0] slot1;
  logic [1:0]       cnt;
  logic             take;

  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign rdata = slot0;
  assign take  = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({wr, take})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({wr, take})
      2'b10: begin
        if (cnt == 2'd0) begin
          slot0 <= wdata;
        end else begin
          slot1 <= wdata;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          slot0 <= wdata;
        end else begin
          slot0 <= slot1;
          slot1 <= wdata;
        end
      end
      default: begin
      end
    endcase
  end

  // a word is never written into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("result buffer overflow");
  // occupancy never exceeds two words
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");

endmodule

[rtl/min_max_tracking_stack.sv]
// Top level of the min/max tracking stack: control, count and the cell row.
// Depends on mmts_pkg, mmts_cell and mmts_out_buf.
//
// Usage
//   Input channel (in_valid/in_ready) carries one word per operation: func
//   selects push of value, pop of the top, or read of the entry at index
//   (counted from the bottom, 0 = oldest). Output channel (out_valid/
//   out_ready) returns exactly one word per operation: ok, read_value,
//   top_value, minimum, maximum and count as seen after the operation.
//   Value fields read as zero on an empty stack; read_value is zero on a failed read.
//   Timing: push, pop, refused operations and a read of the top entry
//   write their word into the result buffer when accepted, one item per
//   cycle while the buffer is not full. A read of an entry below the top
//   loads the read carry chain, which moves the entry up one cell per
//   cycle; no input is taken while it runs, and its word is written when
//   the entry reaches the top cell.
//   Reset clears the count (empty stack) and the result buffer; no clearing
//   pass is needed. A stalled receiver is absorbed by a two-word result
//   buffer; input is taken while at most one word waits, so a stall never
//   loses or repeats a word.
module min_max_tracking_stack #(
  parameter int DEPTH      = mmts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mmts_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mmts_pkg::FUNC_W-1:0]  func,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic [mmts_pkg::IDX_W-1:0]   index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic signed [DATA_WIDTH-1:0] read_value,
  output logic signed [DATA_WIDTH-1:0] top_value,
  output logic signed [DATA_WIDTH-1:0] minimum,
  output logic signed [DATA_WIDTH-1:0] maximum,
  output logic [CNT_W-1:0]             count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int IDX_W = mmts_pkg::IDX_W;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int RES_W = 1 + 4 * DATA_WIDTH + CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     fill_next;
  logic [PTR_W-1:0]     scan_cnt;
  logic [PTR_W-1:0]     scan_cnt_next;

  // cell row, cell 0 is the top of the stack
  logic signed [DATA_WIDTH-1:0] elem_a  [DEPTH];
  logic signed [DATA_WIDTH-1:0] pmin_a  [DEPTH];
  logic signed [DATA_WIDTH-1:0] pmax_a  [DEPTH];
  logic signed [DATA_WIDTH-1:0] carry_a [DEPTH];

  mmts_pkg::cell_ctrl_t         ctrl;
  logic signed [DATA_WIDTH-1:0] new_min;
  logic signed [DATA_WIDTH-1:0] new_max;

  logic             acc;
  logic             is_push;
  logic             is_pop;
  logic             is_read;
  logic             push_ok;
  logic             pop_ok;
  logic             rd_ok;
  logic [CMP_W-1:0] pos_wide;
  logic [PTR_W-1:0] pos;
  logic             buf_full;
  logic             res_wr;
  logic             scan_done;

  logic                         res_ok;
  logic signed [DATA_WIDTH-1:0] res_rd;
  logic signed [DATA_WIDTH-1:0] res_top;
  logic signed [DATA_WIDTH-1:0] res_min;
  logic signed [DATA_WIDTH-1:0] res_max;
  logic [RES_W-1:0]             res_word;
  logic [RES_W-1:0]             out_word;

  // ---------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------
  assign in_ready  = (state == ST_IDLE) && !buf_full;
  assign acc       = in_valid && in_ready;
  assign is_push   = (func == mmts_pkg::FUNC_PUSH);
  assign is_pop    = (func == mmts_pkg::FUNC_POP);
  assign is_read   = (func == mmts_pkg::FUNC_READ);
  assign push_ok   = (fill != CNT_W'(DEPTH));
  assign pop_ok    = (fill != '0);
  assign rd_ok     = (CMP_W'(index) < CMP_W'(fill));

  // distance of the requested entry below the top (valid when rd_ok)
  assign pos_wide  = CMP_W'(fill) - CMP_W'(1) - CMP_W'(index);
  assign pos       = pos_wide[PTR_W-1:0];

  assign scan_done = (state == ST_SCAN) && (scan_cnt == '0);

  // prefix min/max of the entry being pushed
  always_comb begin
    if (fill == '0) begin
      new_min = value;
      new_max = value;
    end else begin
      new_min = (value < pmin_a[0]) ? value : pmin_a[0];
      new_max = (value > pmax_a[0]) ? value : pmax_a[0];
    end
  end

  always_comb begin
    ctrl.push  = acc && is_push && push_ok;
    ctrl.pop   = acc && is_pop && pop_ok;
    ctrl.load  = acc && is_read && rd_ok && (pos != '0);
    ctrl.shift = (state == ST_SCAN);
  end

  // ---------------------------------------------------------------
  // Control: count, FSM and scan counter
  // ---------------------------------------------------------------
  always_comb begin
    fill_next     = fill;
    state_next    = state;
    scan_cnt_next = scan_cnt;
    if (ctrl.push) begin
      fill_next = fill + CNT_W'(1);
    end else if (ctrl.pop) begin
      fill_next = fill - CNT_W'(1);
    end
    unique case (state)
      ST_IDLE: begin
        if (ctrl.load) begin
          state_next    = ST_SCAN;
          scan_cnt_next = pos - PTR_W'(1);
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = ST_IDLE;
        end else begin
          scan_cnt_next = scan_cnt - PTR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  // ---------------------------------------------------------------
  // Result word, built from the state as it stands after the operation
  // ---------------------------------------------------------------
  assign res_wr = (acc && !ctrl.load) || scan_done;

  always_comb begin
    res_ok  = 1'b0;
    res_rd  = '0;
    res_top = '0;
    res_min = '0;
    res_max = '0;
    if (scan_done) begin
      // entry has arrived at the top of the carry chain
      res_ok  = 1'b1;
      res_rd  = carry_a[0];
      res_top = elem_a[0];
      res_min = pmin_a[0];
      res_max = pmax_a[0];
    end else if (ctrl.push) begin
      res_ok  = 1'b1;
      res_top = value;
      res_min = new_min;
      res_max = new_max;
    end else if (ctrl.pop) begin
      res_ok = 1'b1;
      if (fill > CNT_W'(1)) begin
        res_top = elem_a[1];
        res_min = pmin_a[1];
        res_max = pmax_a[1];
      end
    end else begin
      // read of the top entry, or a refused / unknown operation
      if (is_read && rd_ok) begin
        res_ok = 1'b1;
        res_rd = elem_a[0];
      end
      if (fill != '0) begin
        res_top = elem_a[0];
        res_min = pmin_a[0];
        res_max = pmax_a[0];
      end
    end
  end

  assign res_word = {res_ok, res_rd, res_top, res_min, res_max, fill_next};

  // ---------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] up_elem;
    logic signed [DATA_WIDTH-1:0] up_min;
    logic signed [DATA_WIDTH-1:0] up_max;
    logic signed [DATA_WIDTH-1:0] dn_elem;
    logic signed [DATA_WIDTH-1:0] dn_min;
    logic signed [DATA_WIDTH-1:0] dn_max;
    logic signed [DATA_WIDTH-1:0] dn_carry;

    if (i == 0) begin : g_top
      assign up_elem = value;
      assign up_min  = new_min;
      assign up_max  = new_max;
    end else begin : g_mid_up
      assign up_elem = elem_a[i-1];
      assign up_min  = pmin_a[i-1];
      assign up_max  = pmax_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign dn_elem  = '0;
      assign dn_min   = '0;
      assign dn_max   = '0;
      assign dn_carry = '0;
    end else begin : g_mid_dn
      assign dn_elem  = elem_a[i+1];
      assign dn_min   = pmin_a[i+1];
      assign dn_max   = pmax_a[i+1];
      assign dn_carry = carry_a[i+1];
    end

    mmts_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .up_elem  (up_elem),
      .up_min   (up_min),
      .up_max   (up_max),
      .dn_elem  (dn_elem),
      .dn_min   (dn_min),
      .dn_max   (dn_max),
      .dn_carry (dn_carry),
      .elem     (elem_a[i]),
      .pmin     (pmin_a[i]),
      .pmax     (pmax_a[i]),
      .carry    (carry_a[i])
    );
  end

  // ---------------------------------------------------------------
  // Output buffer
  // ---------------------------------------------------------------
  mmts_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_word),
    .full  (buf_full),
    .valid (out_valid),
    .ready (out_ready),
    .rdata (out_word)
  );

  assign {ok, read_value, top_value, minimum, maximum, count} = out_word;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // count never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("stack count above capacity");
  // an accepted push grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("push did not advance count");
  // a deep read starts a scan and leaves the count alone until it ends
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (state == ST_SCAN) && $stable(fill))
    else $error("deep read did not enter scan");
  // no word is taken in while the carry chain is moving
  a_scan_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !in_ready)
    else $error("input accepted during scan");

endmodule

[bench/min_max_tracking_stack_chk.sv]
// Scoreboard for the min/max tracking stack: watches both channels, keeps
// its own copy of the stack and compares each result word field by field.
// Depends on mmts_pkg.
`timescale 1ns / 1ps

module min_max_tracking_stack_chk #(
  parameter int DEPTH = mmts_pkg::DEPTH_DEF,
  parameter int DW    = mmts_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [mmts_pkg::FUNC_W-1:0]   func,
  input  logic signed [DW-1:0]          value,
  input  logic [mmts_pkg::IDX_W-1:0]    index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          ok,
  input  logic signed [DW-1:0]          read_value,
  input  logic signed [DW-1:0]          top_value,
  input  logic signed [DW-1:0]          minimum,
  input  logic signed [DW-1:0]          maximum,
  input  logic [CNT_W-1:0]              count,
  output int                            fail_count,
  output int                            words_due
);

  typedef struct packed {
    logic                 ok;
    logic signed [DW-1:0] read_value;
    logic signed [DW-1:0] top_value;
    logic signed [DW-1:0] minimum;
    logic signed [DW-1:0] maximum;
    logic [CNT_W-1:0]     count;
  } stack_view_t;

  // Mirror of the stack: entries plus running min/max from the bottom up.
  logic signed [DW-1:0] entries [DEPTH];
  logic signed [DW-1:0] low_upto [DEPTH];
  logic signed [DW-1:0] high_upto [DEPTH];
  int fill = 0;
  int fails = 0;
  stack_view_t views [$];

  initial begin
    fail_count = 0;
    words_due = 0;
  end

  function automatic stack_view_t apply_to_stack(input logic [mmts_pkg::FUNC_W-1:0] op,
                                                 input logic signed [DW-1:0] v,
                                                 input logic [mmts_pkg::IDX_W-1:0] ix);
    stack_view_t r;
    r = '0;
    case (op)
      mmts_pkg::FUNC_PUSH: begin
        if (fill < DEPTH) begin
          entries[fill] = v;
          if (fill == 0) begin
            low_upto[fill] = v;
            high_upto[fill] = v;
          end else begin
            low_upto[fill] = (v < low_upto[fill-1]) ? v : low_upto[fill-1];
            high_upto[fill] = (v > high_upto[fill-1]) ? v : high_upto[fill-1];
          end
          fill++;
          r.ok = 1'b1;
        end
      end
      mmts_pkg::FUNC_POP: begin
        if (fill > 0) begin
          fill--;
          r.ok = 1'b1;
        end
      end
      mmts_pkg::FUNC_READ: begin
        if (ix < fill) begin
          r.read_value = entries[ix];
          r.ok = 1'b1;
        end
      end
      default: ;  // unused code: nothing changes, ok stays low
    endcase
    if (fill > 0) begin
      r.top_value = entries[fill-1];
      r.minimum = low_upto[fill-1];
      r.maximum = high_upto[fill-1];
    end
    r.count = CNT_W'(fill);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    stack_view_t want;
    if (rst) begin
      views.delete();
      fill = 0;
    end else begin
      // new expectation goes to the back first, so a same-edge result
      // still pairs with the oldest one
      if (in_valid && in_ready)
        views.insert(views.size(), apply_to_stack(func, value, index));
      if (out_valid && out_ready) begin
        if (views.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = views.pop_front();
          check_field("ok", 64'(want.ok), 64'(ok));
          check_field("read_value", 64'(want.read_value), 64'(read_value));
          check_field("top_value", 64'(want.top_value), 64'(top_value));
          check_field("minimum", 64'(want.minimum), 64'(minimum));
          check_field("maximum", 64'(want.maximum), 64'(maximum));
          check_field("count", 64'(want.count), 64'(count));
        end
      end
    end
    fail_count <= fails;
    words_due <= views.size();
  end

endmodule

[bench/min_max_tracking_stack_tb.sv]
// Top of the min/max tracking stack bench: clock, reset, stimulus, output
// stalls and verdict. Depends on mmts_pkg, the block and the scoreboard.
`timescale 1ns / 1ps

module min_max_tracking_stack_tb;

  localparam int DW = mmts_pkg::DATA_WIDTH_DEF;
  localparam int CAP = mmts_pkg::DEPTH_DEF;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int FUNC_W = mmts_pkg::FUNC_W;
  localparam int IDX_W = mmts_pkg::IDX_W;
  // Fourth func code: the block ignores it but still answers.
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic signed [DW-1:0] value;
  logic [IDX_W-1:0]     index;
  logic                 out_valid;
  logic                 out_ready;
  logic                 ok;
  logic signed [DW-1:0] read_value;
  logic signed [DW-1:0] top_value;
  logic signed [DW-1:0] minimum;
  logic signed [DW-1:0] maximum;
  logic [CNT_W-1:0]     count;
  int                   fail_count;
  int                   words_due;

  // Entries the stack will hold once every sent word has been applied.
  // Only used to steer the stimulus; the scoreboard predicts on its own.
  int stack_level = 0;

  // Idle behavior of each side: 0 never idles, 1 idles now and then,
  // 2 idles most of the time. Redrawn at random so both calm and busy
  // stretches hit every part of the block's work.
  int feed_mode = 1;
  int drain_mode = 1;

  always #5 clk = ~clk;

  min_max_tracking_stack uut (.*);

  min_max_tracking_stack_chk chk (.*);

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) feed_mode <= $urandom_range(0, 2);
    if ($urandom_range(0, 63) == 0) drain_mode <= $urandom_range(0, 2);
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      default: return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  // Word values: mostly random, with extremes and a narrow band so that
  // ties and new minimum/maximum both show up often.
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '1;
      3: return DW'($urandom_range(0, 40)) - DW'(20);
      default: return DW'($urandom);
    endcase
  endfunction

  // Read positions: the top, somewhere inside, past the top, or anywhere.
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return (stack_level > 0) ? IDX_W'(stack_level - 1) : '0;
      1: return (stack_level > 0) ? IDX_W'($urandom_range(0, stack_level - 1)) : '0;
      2: return (stack_level < CAP) ? IDX_W'($urandom_range(stack_level, CAP - 1))
                                    : IDX_W'(CAP - 1);
      default: return IDX_W'($urandom_range(0, CAP - 1));
    endcase
  endfunction

  // Offer one word and hold it until taken. Valid stays high across
  // back-to-back words; it only drops when a gap is drawn.
  task automatic send_word(input logic [FUNC_W-1:0] op, input logic [DW-1:0] v,
                           input logic [IDX_W-1:0] ix);
    int gap;
    gap = draw_gap(feed_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    value <= v;
    index <= ix;
    do @(posedge clk); while (!in_ready);
    if (op == mmts_pkg::FUNC_PUSH && stack_level < CAP) stack_level++;
    else if (op == mmts_pkg::FUNC_POP && stack_level > 0) stack_level--;
  endtask

  // Random word with the given push/pop/read weights (percent); the rest
  // is the ignored code.
  task automatic send_random(input int push_pct, input int pop_pct, input int read_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      send_word(mmts_pkg::FUNC_PUSH, pick_value(), IDX_W'($urandom));
    else if (r < push_pct + pop_pct)
      send_word(mmts_pkg::FUNC_POP, pick_value(), IDX_W'($urandom));
    else if (r < push_pct + pop_pct + read_pct)
      send_word(mmts_pkg::FUNC_READ, pick_value(), pick_index());
    else
      send_word(FUNC_NONE, pick_value(), IDX_W'($urandom));
  endtask

  // Output side: ready drops for a drawn gap, which may be zero, before each word.
  initial begin
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(drain_mode);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int at_full;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= mmts_pkg::FUNC_PUSH;
    value <= '0;
    index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty stack: pop, read and the ignored code all fail with zero fields.
    send_word(mmts_pkg::FUNC_POP, '0, '0);
    send_word(mmts_pkg::FUNC_READ, '0, '0);
    send_word(FUNC_NONE, '1, '1);
    // Extremes, zero and minus one; min/max must follow signed order.
    send_word(mmts_pkg::FUNC_PUSH, WORD_MIN, '0);
    send_word(mmts_pkg::FUNC_PUSH, WORD_MAX, '0);
    send_word(mmts_pkg::FUNC_PUSH, '0, '0);
    send_word(mmts_pkg::FUNC_PUSH, '1, '0);
    send_word(mmts_pkg::FUNC_PUSH, DW'(1), '0);
    // Oldest entry (longest carry), the top, one past the top, far out.
    send_word(mmts_pkg::FUNC_READ, '0, IDX_W'(0));
    send_word(mmts_pkg::FUNC_READ, '0, IDX_W'(4));
    send_word(mmts_pkg::FUNC_READ, '0, IDX_W'(5));
    send_word(mmts_pkg::FUNC_READ, '1, '1);
    send_word(FUNC_NONE, WORD_MAX, '1);
    // Pop down to empty, then one pop too many.
    repeat (6) send_word(mmts_pkg::FUNC_POP, '0, '0);
    // Equal values tie on min and max.
    send_word(mmts_pkg::FUNC_PUSH, DW'(5), '0);
    send_word(mmts_pkg::FUNC_PUSH, DW'(5), '0);
    send_word(mmts_pkg::FUNC_READ, '0, IDX_W'(1));
    send_word(mmts_pkg::FUNC_POP, '0, '0);
    send_word(mmts_pkg::FUNC_POP, '0, '0);

    // Shallow random mix: many empty and near-empty states.
    for (int n = 0; n < 120; n++) begin
      if (stack_level <= 2) send_random(50, 20, 25);
      else if (stack_level >= 24) send_random(20, 40, 35);
      else send_random(35, 25, 35);
    end

    // Fill to capacity, keep pushing a little against the full stack,
    // then back off with mostly pops.
    at_full = 0;
    while (at_full < 6) begin
      send_random(88, 1, 10);
      if (stack_level == CAP) at_full++;
    end
    repeat (30) send_random(10, 60, 25);

    in_valid <= 1'b0;

    // the scoreboard's pending count is registered, so it trails the last accept
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (deep reads at full depth
  // with both sides idling their longest).
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
